FILE: hdl/gdjs_pkg.sv
// shared types and constants for the greedy deadline job sequencer
`default_nettype none

package gdjs_pkg;

  localparam int MAX_JOBS   = 256;
  localparam int MAX_SLOTS  = 256;

  localparam int PROFIT_W   = 16;
  localparam int DEADLINE_W = 9;
  localparam int KEY_W      = PROFIT_W + DEADLINE_W;
  localparam int DONE_W     = 9;
  localparam int SUM_W      = 24;

  localparam int CNT_W      = $clog2(MAX_JOBS + 1);
  localparam int SLOT_CW    = $clog2(MAX_SLOTS + 1);

  // slot map is searched one group of CHUNK_W slots per cycle
  localparam int CHUNK_W    = 16;
  localparam int OFF_W      = $clog2(CHUNK_W);
  localparam int NCHUNK     = (MAX_SLOTS + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_IW   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int NCHUNK_P   = 1 << CHUNK_IW;

  typedef struct packed {
    logic [PROFIT_W-1:0]   job_profit;
    logic [DEADLINE_W-1:0] job_deadline;
    logic                  last_job;
  } job_t;

  typedef struct packed {
    logic [DONE_W-1:0] jobs_done;
    logic [SUM_W-1:0]  total_profit;
  } res_t;

  // one sort cell: profit in the high bits, deadline in the low bits
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [KEY_W-1:0] key;
  } chain_op_t;

  typedef struct packed {
    logic               start;
    logic               clear;
    logic [SLOT_CW-1:0] deadline;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POP,
    ST_WAIT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/greedy_deadline_job_sequencer.sv
// top level: job collection, greedy scheduling and result register
//
//  channel | signals                          | word
//  --------+----------------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o / in_i   | job_t: profit, deadline, last_job
//  out     | out_valid_o / out_ready_i / out_o| res_t: jobs_done, total_profit
//
// each job is inserted into the sort chain as it arrives, in key order
// after the closing word every held job leaves the chain head, and each job with a nonzero
// deadline is searched for its slot one group of CHUNK_W slots at a time, latest first
// the result is registered once the output is free; in_ready_o stays low from the closing word until then
// reset empties the chain and clears the slot map at once
// a stalled result holds only the hand-off of the next set's result
`default_nettype none

module greedy_deadline_job_sequencer
  import gdjs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]    cnt_q;
  logic [PROFIT_W-1:0] profit_q;
  logic [DONE_W-1:0]   done_q;
  logic [SUM_W-1:0]    sum_q;
  logic                out_valid_q;
  res_t                out_q;

  chain_op_t chain_op;
  entry_t    head;
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  logic                  in_fire;
  logic                  room;
  logic [CNT_W-1:0]      cnt_after;
  logic [DEADLINE_W-1:0] head_dl;
  logic [PROFIT_W-1:0]   head_profit;
  logic [SLOT_CW-1:0]    head_slot;
  logic                  out_free;
  logic [SUM_W:0]        sum_wide;

  gdjs_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (chain_op),
    .head_o (head)
  );

  gdjs_slots u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign room        = (32'(cnt_q) < MAX_JOBS);
  assign cnt_after   = room ? (cnt_q + CNT_W'(1)) : cnt_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign head_dl     = head.key[DEADLINE_W-1:0];
  assign head_profit = head.key[KEY_W-1:DEADLINE_W];
  // deadlines past the slot range use the last slot
  assign head_slot   = (32'(head_dl) > MAX_SLOTS) ? SLOT_CW'(MAX_SLOTS) : SLOT_CW'(head_dl);

  assign sum_wide    = {1'b0, sum_q} + (SUM_W + 1)'(profit_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && in_i.last_job) begin
          state_d = (cnt_after == '0) ? ST_DONE : ST_POP;
        end
      end
      ST_POP: begin
        if (head_slot != '0) begin
          state_d = ST_WAIT;
        end else if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_WAIT: begin
        if (srch_rsp.done) begin
          state_d = (cnt_q == '0) ? ST_DONE : ST_POP;
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs to the chain and the slot search
  always_comb begin
    chain_op       = '0;
    chain_op.key   = {in_i.job_profit, in_i.job_deadline};
    srch_req       = '0;
    srch_req.deadline = head_slot;
    unique case (state_q)
      ST_LOAD: chain_op.ins = in_fire && room;
      ST_POP: begin
        chain_op.shift = 1'b1;
        srch_req.start = (head_slot != '0);
      end
      ST_WAIT: ;
      ST_DONE: srch_req.clear = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      done_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) cnt_q <= cnt_after;
        end
        ST_POP: cnt_q <= cnt_q - CNT_W'(1);
        ST_WAIT: begin
          if (srch_rsp.hit) begin
            if (done_q != '1) done_q <= done_q + DONE_W'(1);
            sum_q <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
          end
        end
        ST_DONE: begin
          if (out_free) begin
            cnt_q       <= '0;
            done_q      <= '0;
            sum_q       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_POP) profit_q <= head_profit;
    if (state_q == ST_DONE && out_free) begin
      out_q.jobs_done    <= done_q;
      out_q.total_profit <= sum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: hdl/gdjs_cell.sv
// one cell of the sorted insertion chain
`default_nettype none

module gdjs_cell
  import gdjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  chain_op_t op_i,
  input  entry_t    prev_i,
  input  logic      prev_gt_i,
  input  entry_t    next_i,
  output entry_t    ent_o,
  output logic      gt_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;

  // invalid cells rank below everything
  assign gt_o  = !valid_q || (op_i.key > key_q);
  assign ent_o = '{valid: valid_q, key: key_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (op_i.shift) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
    end else if (op_i.ins) begin
      if (prev_gt_i) begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
      end else if (gt_o) begin
        valid_d = 1'b1;
        key_d   = op_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

FILE: hdl/gdjs_chain.sv
// row of sort cells, largest key at the head
`default_nettype none

module gdjs_chain
  import gdjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  chain_op_t op_i,
  output entry_t    head_o
);

  entry_t ent [MAX_JOBS];
  logic   gt  [MAX_JOBS];

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    entry_t prev_ent, next_ent;
    logic   prev_gt;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[i+1];
    end

    gdjs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op_i),
      .prev_i    (prev_ent),
      .prev_gt_i (prev_gt),
      .next_i    (next_ent),
      .ent_o     (ent[i]),
      .gt_o      (gt[i])
    );
  end

  assign head_o = ent[0];

endmodule

`default_nettype wire

FILE: hdl/gdjs_slots.sv
// slot map and latest-free-slot search, one group of slots per cycle
`default_nettype none

module gdjs_slots
  import gdjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srch_req_t req_i,
  output srch_rsp_t rsp_o
);

  logic [CHUNK_W-1:0]  map_q [NCHUNK_P];
  logic                busy_q;
  logic [CHUNK_IW-1:0] chunk_q;
  logic [OFF_W-1:0]    off_q;

  logic [CHUNK_W-1:0]  row;
  logic [CHUNK_W-1:0]  low_mask;
  logic [CHUNK_W-1:0]  free;
  logic                hit;
  logic [OFF_W-1:0]    pos;
  logic [31:0]         start_idx;

  function automatic logic [OFF_W-1:0] top_bit(input logic [CHUNK_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      if (v[j]) idx = OFF_W'(j);
    end
    return idx;
  endfunction

  assign row       = map_q[chunk_q];
  assign low_mask  = {CHUNK_W{1'b1}} >> (OFF_W'(CHUNK_W - 1) - off_q);
  assign free      = ~row & low_mask;
  assign hit       = |free;
  assign pos       = top_bit(free);
  // deadline is 1-based, the map is 0-based
  assign start_idx = 32'(req_i.deadline) - 32'd1;

  assign rsp_o.done = busy_q && (hit || (chunk_q == '0));
  assign rsp_o.hit  = busy_q && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      for (int k = 0; k < NCHUNK_P; k++) map_q[k] <= '0;
    end else if (req_i.clear) begin
      busy_q <= 1'b0;
      for (int k = 0; k < NCHUNK_P; k++) map_q[k] <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (hit) begin
        map_q[chunk_q][pos] <= 1'b1;
        busy_q              <= 1'b0;
      end else if (chunk_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      chunk_q <= start_idx[OFF_W +: CHUNK_IW];
      off_q   <= start_idx[OFF_W-1:0];
    end else if (busy_q && !hit && (chunk_q != '0)) begin
      chunk_q <= chunk_q - CHUNK_IW'(1);
      off_q   <= '1;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gdjs_checker.sv
// port-level checks for the job sequencer, bound to the top level
`default_nettype none

module gdjs_checker
  import gdjs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input job_t in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input res_t out_o
);

  // a pending result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed or dropped while stalled");

  // the closing word starts scheduling, so input is closed next cycle
  a_close_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.last_job |=> !in_ready_o)
    else $error("input accepted right after the closing word");

  // no jobs placed means no profit
  a_zero_jobs_zero_profit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.jobs_done == '0) |-> (out_o.total_profit == '0))
    else $error("profit reported with no placed jobs");

  // never more jobs placed than the store holds
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_o.jobs_done) <= MAX_JOBS))
    else $error("more jobs placed than held");

endmodule

bind greedy_deadline_job_sequencer gdjs_checker u_gdjs_checker (.*);

`default_nettype wire
